// ===== design/trwl_pkg.sv =====
// Package for the ticket reader-writer lock: codes, field widths, defaults.
// No dependencies.
package trwl_pkg;
	localparam int MaxReadersDef = 16;
	localparam int MaxWaitersDef = 16;
	localparam int IdW = 16;
	localparam int TicketW = 8;

	typedef enum logic [1:0] {
		OP_ACQUIRE = 2'd0,
		OP_TRY     = 2'd1,
		OP_RELEASE = 2'd2,
		OP_CANCEL  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_GRANTED   = 3'd0,
		ST_QUEUED    = 3'd1,
		ST_DEADLOCK  = 3'd2,
		ST_BUSY      = 3'd3,
		ST_NOT_LOCK  = 3'd4,
		ST_CANCELLED = 3'd5,
		ST_FULL      = 3'd6,
		ST_NO_WAITER = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		WS_EMPTY     = 2'd0,
		WS_WAITING   = 2'd1,
		WS_CANCELLED = 2'd2
	} wstate_t;
endpackage

// ===== design/ticket_reader_writer_lock_unit.sv =====
// Top level of the ticket reader-writer lock.
// Depends on trwl_pkg. Tables live in memories with registered reads.
//
// channel  dir  fields (tdata low bit up)                      tuser
// s_axis   in   requester_id[15:0], wants_write[16]            operation[1:0]
// m_axis   out  subject_id[15:0], subject_write[16]            status[2:0], tlast=last
//
// Every request first scans the reader table; cancel then also scans the
// waiter table. Each cascade round scans up to MAX_WAITERS waiter entries,
// then applies the hit and, for a grant, emits the held result and loads
// the grant in its place; the closing scan ends in an emit. Every table scan
// reads one memory entry at a time, checking its data before the next address.
// A result is held until the next one is known, so tlast is right,
// and then waits in the output register until taken; the sequencer stalls
// there. arst_n clears all control state and the valid/state flags
// (flip-flops); id, ticket and mode memories are not cleared.
module ticket_reader_writer_lock_unit #(
	parameter int MAX_READERS = trwl_pkg::MaxReadersDef,
	parameter int MAX_WAITERS = trwl_pkg::MaxWaitersDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // requester_id[15:0], wants_write[16], zero pad
	input  logic [1:0]  s_axis_tuser,  // operation[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // subject_id[15:0], subject_write[16], zero pad
	output logic [2:0]  m_axis_tuser,  // status[2:0]
	output logic        m_axis_tlast
);
	localparam int RW = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
	localparam int WW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
	localparam int RCW = $clog2(MAX_READERS + 1);
	localparam int TW = trwl_pkg::TicketW;
	localparam int IW = trwl_pkg::IdW;

	typedef enum logic [3:0] {
		S_IDLE, S_RSCAN, S_RCHK, S_DECIDE, S_WSCAN, S_WCHK, S_CSCAN, S_CCHK,
		S_CAPPLY, S_EMIT, S_GLOAD
	} state_t;

	// memories
	logic [IW-1:0] rid_mem [MAX_READERS];
	logic [IW-1:0] wid_mem [MAX_WAITERS];
	logic [TW-1:0] wtk_mem [MAX_WAITERS];
	logic          wmd_mem [MAX_WAITERS];
	logic [IW-1:0] rid_rd_q, wid_rd_q;
	logic [TW-1:0] wtk_rd_q;
	logic          wmd_rd_q;
	logic [MAX_READERS-1:0] rvalid_q;
	trwl_pkg::wstate_t wst_q [MAX_WAITERS];

	state_t state_q, ret_q;
	trwl_pkg::op_t op_q;
	logic [IW-1:0] id_q;
	logic w_q;
	logic [TW-1:0] next_q, serve_q;
	logic write_held_q, writer_valid_q;
	logic [IW-1:0] writer_id_q;
	logic [RCW-1:0] rcount_q;
	logic [RW:0] ridx_q;
	logic [WW:0] widx_q;
	logic holds_q, rmatch_q;
	logic [RW-1:0] rmatch_idx_q;
	logic wfound_q;
	logic [WW-1:0] wfound_idx_q;
	logic [TW:0] best_d_q;
	logic [WW:0] round_q;
	logic out_valid_q, out_last_q, out_w_q;
	logic [IW-1:0] out_id_q;
	trwl_pkg::status_t out_st_q;
	logic [IW-1:0] gnt_id_q;
	logic gnt_w_q;

	logic [RW-1:0] free_slot;
	logic free_ok;
	logic [WW-1:0] free_w;
	logic free_w_ok;
	logic [RW-1:0] ra;
	logic [WW-1:0] wa;
	logic [TW:0] tk_gap;
	logic wcand;
	logic idle_tk;

	assign ra = ridx_q[RW-1:0];
	assign wa = widx_q[WW-1:0];
	assign idle_tk = (next_q == serve_q);
	assign tk_gap = {1'b0, wtk_rd_q - serve_q};
	assign wcand = (wst_q[wa] == trwl_pkg::WS_WAITING) && (wid_rd_q == id_q) &&
		(tk_gap < best_d_q);

	// lowest free reader slot and waiter entry (flag scans)
	always_comb begin
		free_slot = '0;
		free_ok = 1'b0;
		for (int i = MAX_READERS - 1; i >= 0; i--) begin
			if (!rvalid_q[i]) begin
				free_slot = RW'(i);
				free_ok = 1'b1;
			end
		end
		free_w = '0;
		free_w_ok = 1'b0;
		for (int i = MAX_WAITERS - 1; i >= 0; i--) begin
			if (wst_q[i] == trwl_pkg::WS_EMPTY) begin
				free_w = WW'(i);
				free_w_ok = 1'b1;
			end
		end
	end

	// synchronous memory reads
	always_ff @(posedge clk) begin
		rid_rd_q <= rid_mem[ra];
		wid_rd_q <= wid_mem[wa];
		wtk_rd_q <= wtk_mem[wa];
		wmd_rd_q <= wmd_mem[wa];
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {7'd0, out_w_q, out_id_q};
	assign m_axis_tuser = out_st_q;
	assign m_axis_tlast = out_last_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			next_q <= '0;
			serve_q <= '0;
			write_held_q <= 1'b0;
			writer_valid_q <= 1'b0;
			writer_id_q <= '0;
			rcount_q <= '0;
			rvalid_q <= '0;
			for (int i = 0; i < MAX_WAITERS; i++) wst_q[i] <= trwl_pkg::WS_EMPTY;
			out_valid_q <= 1'b0;
			out_last_q <= 1'b0;
			out_w_q <= 1'b0;
			out_id_q <= '0;
			out_st_q <= trwl_pkg::ST_GRANTED;
			gnt_id_q <= '0;
			gnt_w_q <= 1'b0;
			op_q <= trwl_pkg::OP_ACQUIRE;
			id_q <= '0;
			w_q <= 1'b0;
			ridx_q <= '0;
			widx_q <= '0;
			holds_q <= 1'b0;
			rmatch_q <= 1'b0;
			rmatch_idx_q <= '0;
			wfound_q <= 1'b0;
			wfound_idx_q <= '0;
			best_d_q <= '0;
			round_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						op_q <= trwl_pkg::op_t'(s_axis_tuser);
						id_q <= s_axis_tdata[IW-1:0];
						w_q <= s_axis_tdata[IW];
						ridx_q <= '0;
						holds_q <= 1'b0;
						rmatch_q <= 1'b0;
						state_q <= S_RSCAN;
					end
				end
				// scan reader ids: address issued, data next cycle
				S_RSCAN: state_q <= S_RCHK;
				S_RCHK: begin
					if (rvalid_q[ra] && rid_rd_q == id_q && !rmatch_q) begin
						holds_q <= 1'b1;
						rmatch_q <= 1'b1;
						rmatch_idx_q <= ra;
					end
					if (ridx_q == (RW+1)'(MAX_READERS - 1)) begin
						state_q <= S_DECIDE;
					end else begin
						ridx_q <= ridx_q + 1'b1;
						state_q <= S_RSCAN;
					end
				end
				S_DECIDE: begin
					out_id_q <= id_q;
					out_w_q <= w_q;
					unique case (op_q)
						trwl_pkg::OP_ACQUIRE, trwl_pkg::OP_TRY: begin
							out_last_q <= 1'b1;
							ret_q <= S_IDLE;
							state_q <= S_EMIT;
							if ((writer_valid_q && writer_id_q == id_q) || (w_q && holds_q)) begin
								out_st_q <= trwl_pkg::ST_DEADLOCK;
							end else if (op_q == trwl_pkg::OP_TRY) begin
								if (!idle_tk || write_held_q || (w_q && rcount_q != '0)) begin
									out_st_q <= trwl_pkg::ST_BUSY;
								end else if (w_q) begin
									write_held_q <= 1'b1;
									writer_valid_q <= 1'b1;
									writer_id_q <= id_q;
									out_st_q <= trwl_pkg::ST_GRANTED;
								end else if (!free_ok) begin
									out_st_q <= trwl_pkg::ST_FULL;
								end else begin
									rvalid_q[free_slot] <= 1'b1;
									rid_mem[free_slot] <= id_q;
									rcount_q <= rcount_q + 1'b1;
									out_st_q <= trwl_pkg::ST_GRANTED;
								end
							end else if (idle_tk && !write_held_q &&
									(w_q ? (rcount_q == '0) : free_ok)) begin
								if (w_q) begin
									write_held_q <= 1'b1;
									writer_valid_q <= 1'b1;
									writer_id_q <= id_q;
								end else begin
									rvalid_q[free_slot] <= 1'b1;
									rid_mem[free_slot] <= id_q;
									rcount_q <= rcount_q + 1'b1;
								end
								out_st_q <= trwl_pkg::ST_GRANTED;
							end else if (!free_w_ok) begin
								out_st_q <= trwl_pkg::ST_FULL;
							end else begin
								wst_q[free_w] <= trwl_pkg::WS_WAITING;
								wid_mem[free_w] <= id_q;
								wmd_mem[free_w] <= w_q;
								wtk_mem[free_w] <= next_q;
								next_q <= next_q + 1'b1;
								out_st_q <= trwl_pkg::ST_QUEUED;
							end
						end
						trwl_pkg::OP_RELEASE: begin
							if (w_q ? write_held_q : rmatch_q) begin
								if (w_q) begin
									write_held_q <= 1'b0;
									writer_valid_q <= 1'b0;
								end else begin
									rvalid_q[rmatch_idx_q] <= 1'b0;
									if (rcount_q != '0) rcount_q <= rcount_q - 1'b1;
								end
								// hold the result until the cascade shows what follows
								out_st_q <= trwl_pkg::ST_GRANTED;
								out_last_q <= 1'b0;
								state_q <= S_CSCAN;
								round_q <= '0;
								widx_q <= '0;
								wfound_q <= 1'b0;
							end else begin
								out_st_q <= trwl_pkg::ST_NOT_LOCK;
								out_last_q <= 1'b1;
								ret_q <= S_IDLE;
								state_q <= S_EMIT;
							end
						end
						default: begin
							// cancel: search waiter table for earliest ticket of id
							widx_q <= '0;
							wfound_q <= 1'b0;
							best_d_q <= {1'b1, {TW{1'b0}}};
							state_q <= S_WSCAN;
						end
					endcase
				end
				S_WSCAN: state_q <= S_WCHK;
				S_WCHK: begin
					if (widx_q == (WW+1)'(MAX_WAITERS - 1)) begin
						out_id_q <= id_q;
						widx_q <= '0;
						wfound_q <= 1'b0;
						if (wcand || wfound_q) begin
							if (wcand) begin
								wst_q[wa] <= trwl_pkg::WS_CANCELLED;
								out_w_q <= wmd_rd_q;
							end else begin
								wst_q[wfound_idx_q] <= trwl_pkg::WS_CANCELLED;
							end
							// hold the result until the cascade shows what follows
							out_st_q <= trwl_pkg::ST_CANCELLED;
							out_last_q <= 1'b0;
							round_q <= '0;
							state_q <= S_CSCAN;
						end else begin
							out_st_q <= trwl_pkg::ST_NO_WAITER;
							out_w_q <= w_q;
							out_last_q <= 1'b1;
							ret_q <= S_IDLE;
							state_q <= S_EMIT;
						end
					end else begin
						if (wcand) begin
							best_d_q <= tk_gap;
							wfound_q <= 1'b1;
							wfound_idx_q <= wa;
							out_w_q <= wmd_rd_q;
						end
						widx_q <= widx_q + 1'b1;
						state_q <= S_WSCAN;
					end
				end
				// cascade: find the serving ticket's entry; end on miss, block, last round
				S_CSCAN: begin
					if (round_q == (WW+1)'(MAX_WAITERS)) begin
						out_last_q <= 1'b1;
						ret_q <= S_IDLE;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_CCHK;
					end
				end
				S_CCHK: begin
					if (wst_q[wa] != trwl_pkg::WS_EMPTY && wtk_rd_q == serve_q) begin
						wfound_idx_q <= wa;
						state_q <= S_CAPPLY;
					end else if (widx_q == (WW+1)'(MAX_WAITERS - 1)) begin
						out_last_q <= 1'b1;
						ret_q <= S_IDLE;
						state_q <= S_EMIT;
					end else begin
						widx_q <= widx_q + 1'b1;
						state_q <= S_CSCAN;
					end
				end
				S_CAPPLY: begin
					// read data still addresses the hit entry
					widx_q <= '0;
					if (wst_q[wfound_idx_q] == trwl_pkg::WS_CANCELLED) begin
						wst_q[wfound_idx_q] <= trwl_pkg::WS_EMPTY;
						serve_q <= serve_q + 1'b1;
						round_q <= round_q + 1'b1;
						state_q <= S_CSCAN;
					end else if (write_held_q || (wmd_rd_q ? (rcount_q != '0) : !free_ok)) begin
						out_last_q <= 1'b1;
						ret_q <= S_IDLE;
						state_q <= S_EMIT;
					end else begin
						if (wmd_rd_q) begin
							write_held_q <= 1'b1;
							writer_valid_q <= 1'b1;
							writer_id_q <= wid_rd_q;
						end else begin
							rvalid_q[free_slot] <= 1'b1;
							rid_mem[free_slot] <= wid_rd_q;
							rcount_q <= rcount_q + 1'b1;
						end
						wst_q[wfound_idx_q] <= trwl_pkg::WS_EMPTY;
						serve_q <= serve_q + 1'b1;
						round_q <= round_q + 1'b1;
						// send the held result, then load this grant
						gnt_id_q <= wid_rd_q;
						gnt_w_q <= wmd_rd_q;
						ret_q <= S_GLOAD;
						state_q <= S_EMIT;
					end
				end
				// load a cascade grant as the held result
				S_GLOAD: begin
					out_st_q <= trwl_pkg::ST_GRANTED;
					out_id_q <= gnt_id_q;
					out_w_q <= gnt_w_q;
					out_last_q <= 1'b0;
					state_q <= S_CSCAN;
				end
				S_EMIT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
					end else if (m_axis_tready) begin
						out_valid_q <= 1'b0;
						state_q <= ret_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== tb/trwl_checker.sv =====
// Checker for the ticket reader-writer lock: watches both stream channels,
// predicts each request's results and compares them. Depends on trwl_pkg.
module trwl_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,
	input  logic [1:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [23:0] m_axis_tdata,
	input  logic [2:0]  m_axis_tuser,
	input  logic        m_axis_tlast,
	output int          fail_count,
	output int          pending_results
);
	import trwl_pkg::*;

	localparam int NR = MaxReadersDef;
	localparam int NW = MaxWaitersDef;

	typedef struct packed {
		status_t       status;
		logic [15:0]   subject;
		logic          wr;
		logic          last;
	} lock_result_t;

	lock_result_t expected_q[$];

	// lock state as predicted
	logic [7:0]  ticket_next, ticket_serving;
	logic        wr_held, wr_owner_valid;
	logic [15:0] wr_owner;
	int          readers;
	logic [15:0] rd_id [NR];
	logic        rd_valid [NR];
	logic [15:0] wt_id [NW];
	logic [7:0]  wt_ticket [NW];
	logic        wt_mode [NW];
	wstate_t     wt_state [NW];

	function automatic void push_result(status_t st, logic [15:0] id, logic w);
		lock_result_t r;
		r.status = st;
		r.subject = id;
		r.wr = w;
		r.last = 1'b0;
		expected_q.push_back(r);
	endfunction

	function automatic int free_reader();
		for (int i = 0; i < NR; i++)
			if (!rd_valid[i]) return i;
		return -1;
	endfunction

	function automatic bit is_reader(logic [15:0] id);
		for (int i = 0; i < NR; i++)
			if (rd_valid[i] && rd_id[i] == id) return 1;
		return 0;
	endfunction

	function automatic void grant_read(int s, logic [15:0] id);
		rd_valid[s] = 1'b1;
		rd_id[s] = id;
		readers++;
	endfunction

	function automatic void grant_write(logic [15:0] id);
		wr_held = 1'b1;
		wr_owner_valid = 1'b1;
		wr_owner = id;
	endfunction

	// Grant waiters in ticket order, dropping cancelled tickets.
	function automatic void run_cascade();
		int hit, s;
		for (int round = 0; round < NW; round++) begin
			hit = -1;
			for (int i = 0; i < NW; i++)
				if (hit < 0 && wt_state[i] != WS_EMPTY && wt_ticket[i] == ticket_serving)
					hit = i;
			if (hit < 0) return;
			if (wt_state[hit] == WS_CANCELLED) begin
				wt_state[hit] = WS_EMPTY;
				ticket_serving++;
				continue;
			end
			if (wr_held) return;
			if (wt_mode[hit]) begin
				if (readers != 0) return;
				grant_write(wt_id[hit]);
			end else begin
				s = free_reader();
				if (s < 0) return;
				grant_read(s, wt_id[hit]);
			end
			push_result(ST_GRANTED, wt_id[hit], wt_mode[hit]);
			wt_state[hit] = WS_EMPTY;
			ticket_serving++;
		end
	endfunction

	// Work out all results of one request and queue them.
	function automatic void predict_request(op_t op, logic [15:0] id, logic w);
		bit idle, done;
		int s, pick, first;
		logic [7:0] gap, best_gap;
		idle = (ticket_next == ticket_serving);
		first = expected_q.size();
		case (op)
			OP_ACQUIRE, OP_TRY: begin
				if ((wr_owner_valid && wr_owner == id) || (w && is_reader(id))) begin
					push_result(ST_DEADLOCK, id, w);
				end else if (op == OP_TRY) begin
					if (!idle || wr_held || (w && readers != 0)) begin
						push_result(ST_BUSY, id, w);
					end else if (w) begin
						grant_write(id);
						push_result(ST_GRANTED, id, w);
					end else begin
						s = free_reader();
						if (s < 0) push_result(ST_FULL, id, w);
						else begin
							grant_read(s, id);
							push_result(ST_GRANTED, id, w);
						end
					end
				end else begin
					s = w ? -1 : free_reader();
					if (idle && !wr_held && (w ? readers == 0 : s >= 0)) begin
						if (w) grant_write(id);
						else grant_read(s, id);
						push_result(ST_GRANTED, id, w);
					end else begin
						pick = -1;
						for (int i = 0; i < NW; i++)
							if (pick < 0 && wt_state[i] == WS_EMPTY) pick = i;
						if (pick < 0) push_result(ST_FULL, id, w);
						else begin
							wt_state[pick] = WS_WAITING;
							wt_id[pick] = id;
							wt_mode[pick] = w;
							wt_ticket[pick] = ticket_next;
							ticket_next++;
							push_result(ST_QUEUED, id, w);
						end
					end
				end
			end
			OP_RELEASE: begin
				done = 0;
				if (w) begin
					if (wr_held) begin
						wr_held = 1'b0;
						wr_owner_valid = 1'b0;
						done = 1;
					end
				end else begin
					for (int i = 0; i < NR; i++)
						if (!done && rd_valid[i] && rd_id[i] == id) begin
							rd_valid[i] = 1'b0;
							if (readers != 0) readers--;
							done = 1;
						end
				end
				if (!done) push_result(ST_NOT_LOCK, id, w);
				else begin
					push_result(ST_GRANTED, id, w);
					run_cascade();
				end
			end
			default: begin
				pick = -1;
				best_gap = 8'hFF;
				for (int i = 0; i < NW; i++)
					if (wt_state[i] == WS_WAITING && wt_id[i] == id) begin
						gap = wt_ticket[i] - ticket_serving;
						if (pick < 0 || gap < best_gap) begin
							best_gap = gap;
							pick = i;
						end
					end
				if (pick < 0) push_result(ST_NO_WAITER, id, w);
				else begin
					wt_state[pick] = WS_CANCELLED;
					push_result(ST_CANCELLED, id, wt_mode[pick]);
					run_cascade();
				end
			end
		endcase
		if (expected_q.size() > first)
			expected_q[expected_q.size() - 1].last = 1'b1;
	endfunction

	// Predict on accepted requests, compare accepted results.
	always @(posedge clk or negedge arst_n) begin
		lock_result_t want;
		if (!arst_n) begin
			ticket_next = '0;
			ticket_serving = '0;
			wr_held = 1'b0;
			wr_owner_valid = 1'b0;
			wr_owner = '0;
			readers = 0;
			for (int i = 0; i < NR; i++) rd_valid[i] = 1'b0;
			for (int i = 0; i < NW; i++) wt_state[i] = WS_EMPTY;
			fail_count <= 0;
			pending_results <= 0;
			expected_q.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result: status %0d id %h w %b last %b",
							m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[16], m_axis_tlast);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_q.pop_front();
					if (m_axis_tuser != want.status || m_axis_tdata[15:0] != want.subject
						|| m_axis_tdata[16] != want.wr || m_axis_tlast != want.last
						|| m_axis_tdata[23:17] != '0) begin
						if (fail_count < 10)
							$display("mismatch: expected st %0d id %h w %b last %b, got st %0d id %h w %b last %b",
								want.status, want.subject, want.wr, want.last,
								m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[16], m_axis_tlast);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_request(op_t'(s_axis_tuser), s_axis_tdata[15:0], s_axis_tdata[16]);
			pending_results <= expected_q.size();
		end
	end
endmodule

// ===== tb/tb_ticket_reader_writer_lock_unit.sv =====
// Top of the ticket reader-writer lock testbench: clock, reset, request
// stimulus and verdict. Depends on trwl_pkg, trwl_checker and the lock unit.
module tb_ticket_reader_writer_lock_unit;
	import trwl_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid, s_axis_tready;
	logic [23:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid, m_axis_tready;
	logic [23:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;
	int          fail_count, pending_results;
	int          send_idle_pct, recv_idle_pct;

	ticket_reader_writer_lock_unit DUT (.*);

	trwl_checker checker_i (.*);

	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	// Stall the result side at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tready <= 1'b0;
		else m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Send one request, idling at random before it; valid stays up until the next one.
	task automatic send_request(op_t op, logic [15:0] id, logic w);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {7'd0, w, id};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// Ids from a small pool so requests collide; some from anywhere.
	function automatic logic [15:0] pick_id();
		if ($urandom_range(9) == 0) return 16'($urandom);
		return 16'($urandom_range(5)) ^ 16'hA5A0;
	endfunction

	initial begin
		#20000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int r;
		op_t op;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_ACQUIRE;
		send_idle_pct = 7;
		recv_idle_pct = 54;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, every operation, deadlock, busy, full tables.
		send_request(OP_RELEASE, 16'h0000, 1'b0);
		send_request(OP_RELEASE, 16'hFFFF, 1'b1);
		send_request(OP_CANCEL, 16'hFFFF, 1'b0);
		send_request(OP_TRY, 16'hFFFF, 1'b1);
		send_request(OP_ACQUIRE, 16'hFFFF, 1'b0);
		send_request(OP_TRY, 16'h0000, 1'b0);
		send_request(OP_ACQUIRE, 16'h0001, 1'b1);
		send_request(OP_ACQUIRE, 16'h0002, 1'b0);
		send_request(OP_CANCEL, 16'h0002, 1'b0);
		send_request(OP_RELEASE, 16'h0000, 1'b1);
		send_request(OP_ACQUIRE, 16'h0001, 1'b1);
		send_request(OP_TRY, 16'h0001, 1'b0);
		send_request(OP_RELEASE, 16'h1234, 1'b1);
		// Fill the reader table, then overflow the waiter table.
		for (int i = 0; i < 17; i++) send_request(OP_TRY, 16'(16'h0100 + i), 1'b0);
		send_request(OP_ACQUIRE, 16'h0100, 1'b1);
		for (int i = 0; i < 17; i++) send_request(OP_ACQUIRE, 16'(16'h0200 + i), i[0]);
		// Release readers so the queue drains in long cascades.
		for (int i = 0; i < 17; i++) send_request(OP_RELEASE, 16'(16'h0100 + i), 1'b0);
		send_request(OP_RELEASE, 16'h0000, 1'b1);

		// Random traffic in three idling phases.
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 54 : 0;
			recv_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 7 : 0;
			for (int n = 0; n < 118; n++) begin
				r = $urandom_range(99);
				op = (r < 35) ? OP_ACQUIRE : (r < 50) ? OP_TRY : (r < 85) ? OP_RELEASE : OP_CANCEL;
				send_request(op, pick_id(), 1'($urandom));
			end
		end
		s_axis_tvalid <= 1'b0;
		@(posedge clk);

		while (pending_results != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending_results == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
